FILE: rtl/c8i_pkg.sv
`default_nettype none
package c8i_pkg;

  // geometry and fixed addresses
  localparam int STACK_DEPTH_DEF = 16;
  localparam int SCREEN_W        = 64;
  localparam int SCREEN_H        = 32;
  localparam int ROW_W           = $clog2(SCREEN_H);
  localparam int MEM_DEPTH       = 4096;
  localparam int ADDR_W          = 12;
  localparam int REG_COUNT       = 16;
  localparam int REG_AW          = 4;
  localparam int FONT_BYTES      = 80;
  localparam int IN_W            = 48;
  localparam int OUT_W           = 80;
  localparam logic [ADDR_W-1:0] FONT_BASE = 12'h050;
  localparam logic [ADDR_W-1:0] START_PC  = 12'h200;
  localparam logic [ADDR_W-1:0] ADDR_LAST = 12'hFFF;
  localparam logic [REG_AW-1:0] FLAG_REG  = 4'hF;

  // item kinds carried on tuser
  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_READ  = 2'd3
  } item_op_t;

  // configuration register indexes
  localparam logic CFG_SHIFT_Y = 1'b0;
  localparam logic CFG_JUMP_X  = 1'b1;

  // instruction groups (top nibble)
  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JMP  = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SEQI = 4'h3;
  localparam logic [3:0] OPC_SNEI = 4'h4;
  localparam logic [3:0] OPC_SEQR = 4'h5;
  localparam logic [3:0] OPC_LDI  = 4'h6;
  localparam logic [3:0] OPC_ADDI = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_SNER = 4'h9;
  localparam logic [3:0] OPC_LDX  = 4'hA;
  localparam logic [3:0] OPC_JOFS = 4'hB;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;
  localparam logic [3:0] OPC_KEY  = 4'hE;
  localparam logic [3:0] OPC_MISC = 4'hF;

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;

  // register to register operations
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;

  // misc group sub-codes
  localparam logic [7:0] FN_DELAY_RD = 8'h07;
  localparam logic [7:0] FN_KEY_WAIT = 8'h0A;
  localparam logic [7:0] FN_DELAY_WR = 8'h15;
  localparam logic [7:0] FN_SOUND_WR = 8'h18;
  localparam logic [7:0] FN_IDX_ADD  = 8'h1E;
  localparam logic [7:0] FN_FONT     = 8'h29;
  localparam logic [7:0] FN_BCD      = 8'h33;
  localparam logic [7:0] FN_STORE    = 8'h55;
  localparam logic [7:0] FN_LOAD     = 8'h65;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_DECODE,
    ST_READ_Y,
    ST_EXEC,
    ST_FLAG,
    ST_BCD,
    ST_STORE_RD,
    ST_STORE_WR,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {MR_PC, MR_PC1, MR_IDX} mem_rsel_t;
  typedef enum logic [1:0] {MW_IN, MW_CLR, MW_BCD, MW_STORE} mem_wsel_t;
  typedef enum logic [1:0] {VR_A, VR_Y, VR_CNT} v_rsel_t;
  typedef enum logic [1:0] {VW_EXEC, VW_FLAG, VW_LOAD, VW_CLR} v_wsel_t;

  // controller to datapath
  typedef struct packed {
    logic      accept;
    mem_rsel_t mem_rsel;
    logic      mem_we;
    mem_wsel_t mem_wsel;
    v_rsel_t   v_rsel;
    logic      v_we;
    v_wsel_t   v_wsel;
    logic      ir_hi_ld;
    logic      ir_lo_ld;
    logic      va_ld;
    logic      exec;
    logic      draw_ld;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_exec;
    logic in_is_write;
    logic clr_last;
    logic need_flag;
    logic is_bcd;
    logic is_store;
    logic is_load;
    logic is_draw;
    logic cnt_at_x;
    logic cnt_two;
    logic draw_end;
  } sts_t;

  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // initial memory contents at a given address
  function automatic logic [7:0] boot_byte(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] ofs;
    ofs = a - FONT_BASE;
    if (a >= FONT_BASE && ofs < ADDR_W'(FONT_BYTES)) begin
      return FONT_ROM[ofs[6:0]];
    end
    return 8'h00;
  endfunction

  // one decimal digit of a byte: 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [15:0] prod;
    logic [3:0]  t;
    logic [7:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - ({6'd0, h} * 8'd100);
    prod = 16'(r) * 16'd205;
    t = prod[14:11];
    o = r - ({4'd0, t} * 8'd10);
    case (sel)
      2'd0:    return {6'd0, h};
      2'd1:    return {4'd0, t};
      default: return o;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/c8i_ram.sv
`default_nettype none
module c8i_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/c8i_ctrl.sv
`default_nettype none
module c8i_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire c8i_pkg::sts_t sts,
  output c8i_pkg::cmd_t      cmd
);

  c8i_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= c8i_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    cmd          = '0;
    cmd.mem_rsel = c8i_pkg::MR_PC;
    cmd.mem_wsel = c8i_pkg::MW_IN;
    cmd.v_rsel   = c8i_pkg::VR_A;
    cmd.v_wsel   = c8i_pkg::VW_EXEC;
    in_tready    = 1'b0;
    state_nxt    = state_r;
    unique case (state_r)
      c8i_pkg::ST_CLEAR: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_wsel = c8i_pkg::MW_CLR;
        cmd.v_we     = 1'b1;
        cmd.v_wsel   = c8i_pkg::VW_CLR;
        cmd.cnt_inc  = 1'b1;
        if (sts.clr_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = c8i_pkg::ST_IDLE;
        end
      end
      c8i_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          cmd.mem_we = sts.in_is_write;
          state_nxt  = sts.in_is_exec ? c8i_pkg::ST_FETCH_HI : c8i_pkg::ST_RESP;
        end
      end
      c8i_pkg::ST_FETCH_HI: begin
        cmd.ir_hi_ld = 1'b1;
        cmd.mem_rsel = c8i_pkg::MR_PC1;
        state_nxt    = c8i_pkg::ST_FETCH_LO;
      end
      c8i_pkg::ST_FETCH_LO: begin
        cmd.ir_lo_ld = 1'b1;
        state_nxt    = c8i_pkg::ST_DECODE;
      end
      c8i_pkg::ST_DECODE: begin
        cmd.v_rsel = c8i_pkg::VR_A;
        state_nxt  = c8i_pkg::ST_READ_Y;
      end
      c8i_pkg::ST_READ_Y: begin
        cmd.va_ld  = 1'b1;
        cmd.v_rsel = c8i_pkg::VR_Y;
        state_nxt  = c8i_pkg::ST_EXEC;
      end
      c8i_pkg::ST_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.v_we    = 1'b1;
        cmd.v_wsel  = c8i_pkg::VW_EXEC;
        cmd.cnt_clr = 1'b1;
        if (sts.need_flag)     state_nxt = c8i_pkg::ST_FLAG;
        else if (sts.is_bcd)   state_nxt = c8i_pkg::ST_BCD;
        else if (sts.is_store) state_nxt = c8i_pkg::ST_STORE_RD;
        else if (sts.is_load)  state_nxt = c8i_pkg::ST_LOAD_RD;
        else if (sts.is_draw)  state_nxt = c8i_pkg::ST_DRAW_RD;
        else                   state_nxt = c8i_pkg::ST_RESP;
      end
      c8i_pkg::ST_FLAG: begin
        cmd.v_we   = 1'b1;
        cmd.v_wsel = c8i_pkg::VW_FLAG;
        state_nxt  = c8i_pkg::ST_RESP;
      end
      c8i_pkg::ST_BCD: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_wsel = c8i_pkg::MW_BCD;
        cmd.cnt_inc  = 1'b1;
        if (sts.cnt_two) state_nxt = c8i_pkg::ST_RESP;
      end
      c8i_pkg::ST_STORE_RD: begin
        cmd.v_rsel = c8i_pkg::VR_CNT;
        state_nxt  = c8i_pkg::ST_STORE_WR;
      end
      c8i_pkg::ST_STORE_WR: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_wsel = c8i_pkg::MW_STORE;
        cmd.cnt_inc  = 1'b1;
        state_nxt    = sts.cnt_at_x ? c8i_pkg::ST_RESP : c8i_pkg::ST_STORE_RD;
      end
      c8i_pkg::ST_LOAD_RD: begin
        cmd.mem_rsel = c8i_pkg::MR_IDX;
        state_nxt    = c8i_pkg::ST_LOAD_WR;
      end
      c8i_pkg::ST_LOAD_WR: begin
        cmd.v_we    = 1'b1;
        cmd.v_wsel  = c8i_pkg::VW_LOAD;
        cmd.cnt_inc = 1'b1;
        state_nxt   = sts.cnt_at_x ? c8i_pkg::ST_RESP : c8i_pkg::ST_LOAD_RD;
      end
      c8i_pkg::ST_DRAW_RD: begin
        cmd.mem_rsel = c8i_pkg::MR_IDX;
        state_nxt    = sts.draw_end ? c8i_pkg::ST_FLAG : c8i_pkg::ST_DRAW_WR;
      end
      c8i_pkg::ST_DRAW_WR: begin
        cmd.draw_ld = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = c8i_pkg::ST_DRAW_RD;
      end
      c8i_pkg::ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = c8i_pkg::ST_IDLE;
        end
      end
      default: state_nxt = c8i_pkg::ST_CLEAR;
    endcase
  end

  // result valid holds until taken
  always_comb begin
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

endmodule
`default_nettype wire

FILE: rtl/c8i_datapath.sv
`default_nettype none
module c8i_datapath #(
  parameter int STACK_DEPTH = c8i_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire c8i_pkg::cmd_t                cmd,
  output c8i_pkg::sts_t                     sts,
  input  wire logic [1:0]                   in_tuser,
  input  wire logic [c8i_pkg::IN_W-1:0]     in_tdata,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_index,
  input  wire logic                         cfg_data,
  output logic      [c8i_pkg::OUT_W-1:0]    out_tdata
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int SIX_W = $clog2(STACK_DEPTH);
  localparam int AW    = c8i_pkg::ADDR_W;

  // input fields
  logic [AW-1:0] in_addr;
  logic [7:0]    in_wdata;
  logic [15:0]   in_keys;
  logic [7:0]    in_rnd;
  assign in_addr  = in_tdata[11:0];
  assign in_wdata = in_tdata[19:12];
  assign in_keys  = in_tdata[35:20];
  assign in_rnd   = in_tdata[43:36];

  // architectural and working state
  logic              shift_y_r, jump_x_r;
  logic [1:0]        op_r;
  logic [AW-1:0]     addr_r;
  logic [15:0]       keys_r;
  logic [7:0]        rnd_r;
  logic [AW-1:0]     pc_r;
  logic [15:0]       idx_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [AW-1:0]     stack_r [STACK_DEPTH];
  logic [7:0]        delay_r, sound_r;
  logic [c8i_pkg::SCREEN_W-1:0] frame_r [c8i_pkg::SCREEN_H];
  logic [15:0]       ir_r;
  logic [7:0]        va_r, vy_r;
  logic              flag_r;
  logic [AW-1:0]     cnt_r;
  logic              chg_r, wait_r, fault_r;
  logic [c8i_pkg::OUT_W-1:0] out_r;

  // memories
  logic [AW-1:0]     mem_raddr, mem_waddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic [3:0]        v_raddr, v_waddr;
  logic [7:0]        v_wdata, v_rdata;
  logic              v_we;

  // instruction fields
  logic [3:0] opc, fx, fy, fn;
  logic [7:0] nn;
  logic [AW-1:0] nnn;
  assign opc = ir_r[15:12];
  assign fx  = ir_r[11:8];
  assign fy  = ir_r[7:4];
  assign fn  = ir_r[3:0];
  assign nn  = ir_r[7:0];
  assign nnn = ir_r[11:0];

  logic [AW-1:0] idx_addr;
  assign idx_addr = idx_r[AW-1:0] + cnt_r;

  // execute results
  logic [AW-1:0]    pc2, pc_x;
  logic             wx_en, flag_x, need_flag;
  logic [7:0]       wx_data, vy, src;
  logic [8:0]       sum9;
  logic [16:0]      sum17;
  logic [15:0]      idx_x;
  logic             idx_en, dly_en, snd_en, push_en, pop_en, cls_en, chg_x, wait_x, fault_x;
  logic             down;
  logic [3:0]       key_lo;
  logic [LVL_W-1:0] lvl_m1;

  assign vy     = v_rdata;
  assign pc2    = pc_r + AW'(2);
  assign lvl_m1 = lvl_r - LVL_W'(1);
  assign down   = (va_r < 8'd16) && keys_r[va_r[3:0]];
  assign src    = shift_y_r ? vy : va_r;
  assign sum9   = {1'b0, va_r} + {1'b0, vy};
  assign sum17  = {1'b0, idx_r} + {9'd0, va_r};

  // lowest pressed key
  always_comb begin
    key_lo = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) key_lo = 4'(k);
    end
  end

  // instruction decode and execute
  always_comb begin
    pc_x      = pc2;
    wx_en     = 1'b0;
    wx_data   = 8'd0;
    flag_x    = 1'b0;
    need_flag = 1'b0;
    idx_en    = 1'b0;
    idx_x     = idx_r;
    dly_en    = 1'b0;
    snd_en    = 1'b0;
    push_en   = 1'b0;
    pop_en    = 1'b0;
    cls_en    = 1'b0;
    chg_x     = 1'b0;
    wait_x    = 1'b0;
    fault_x   = 1'b0;
    unique case (opc)
      c8i_pkg::OPC_SYS: begin
        if (ir_r == c8i_pkg::INS_CLS) begin
          cls_en = 1'b1;
          chg_x  = 1'b1;
        end else if (ir_r == c8i_pkg::INS_RET) begin
          if (lvl_r == '0) begin
            fault_x = 1'b1;
          end else begin
            pop_en = 1'b1;
            pc_x   = stack_r[lvl_m1[SIX_W-1:0]];
          end
        end
      end
      c8i_pkg::OPC_JMP: pc_x = nnn;
      c8i_pkg::OPC_CALL: begin
        if (lvl_r >= LVL_W'(STACK_DEPTH)) begin
          fault_x = 1'b1;
        end else begin
          push_en = 1'b1;
          pc_x    = nnn;
        end
      end
      c8i_pkg::OPC_SEQI: if (va_r == nn) pc_x = pc_r + AW'(4);
      c8i_pkg::OPC_SNEI: if (va_r != nn) pc_x = pc_r + AW'(4);
      c8i_pkg::OPC_SEQR: if (va_r == vy) pc_x = pc_r + AW'(4);
      c8i_pkg::OPC_SNER: if (va_r != vy) pc_x = pc_r + AW'(4);
      c8i_pkg::OPC_LDI: begin
        wx_en   = 1'b1;
        wx_data = nn;
      end
      c8i_pkg::OPC_ADDI: begin
        wx_en   = 1'b1;
        wx_data = va_r + nn;
      end
      c8i_pkg::OPC_ALU: begin
        case (fn)
          c8i_pkg::ALU_MOV: begin wx_en = 1'b1; wx_data = vy; end
          c8i_pkg::ALU_OR:  begin wx_en = 1'b1; wx_data = va_r | vy; end
          c8i_pkg::ALU_AND: begin wx_en = 1'b1; wx_data = va_r & vy; end
          c8i_pkg::ALU_XOR: begin wx_en = 1'b1; wx_data = va_r ^ vy; end
          c8i_pkg::ALU_ADD: begin
            wx_en = 1'b1; wx_data = sum9[7:0]; flag_x = sum9[8]; need_flag = 1'b1;
          end
          c8i_pkg::ALU_SUB: begin
            wx_en = 1'b1; wx_data = va_r - vy; flag_x = (va_r >= vy); need_flag = 1'b1;
          end
          c8i_pkg::ALU_SUBN: begin
            wx_en = 1'b1; wx_data = vy - va_r; flag_x = (vy >= va_r); need_flag = 1'b1;
          end
          c8i_pkg::ALU_SHR: begin
            wx_en = 1'b1; wx_data = {1'b0, src[7:1]}; flag_x = src[0]; need_flag = 1'b1;
          end
          c8i_pkg::ALU_SHL: begin
            wx_en = 1'b1; wx_data = {src[6:0], 1'b0}; flag_x = src[7]; need_flag = 1'b1;
          end
          default: ;
        endcase
      end
      c8i_pkg::OPC_LDX: begin
        idx_en = 1'b1;
        idx_x  = {4'd0, nnn};
      end
      c8i_pkg::OPC_JOFS: pc_x = nnn + {4'd0, va_r};
      c8i_pkg::OPC_RND: begin
        wx_en   = 1'b1;
        wx_data = rnd_r & nn;
      end
      c8i_pkg::OPC_DRW: chg_x = 1'b1;
      c8i_pkg::OPC_KEY: begin
        if ((nn == c8i_pkg::KEY_DOWN && down) || (nn == c8i_pkg::KEY_UP && !down)) begin
          pc_x = pc_r + AW'(4);
        end
      end
      c8i_pkg::OPC_MISC: begin
        case (nn)
          c8i_pkg::FN_DELAY_RD: begin wx_en = 1'b1; wx_data = delay_r; end
          c8i_pkg::FN_KEY_WAIT: begin
            if (keys_r == '0) begin
              pc_x   = pc_r;
              wait_x = 1'b1;
            end else begin
              wx_en   = 1'b1;
              wx_data = {4'd0, key_lo};
            end
          end
          c8i_pkg::FN_DELAY_WR: dly_en = 1'b1;
          c8i_pkg::FN_SOUND_WR: snd_en = 1'b1;
          c8i_pkg::FN_IDX_ADD: begin
            idx_en    = 1'b1;
            idx_x     = sum17[15:0];
            flag_x    = (sum17 > 17'h00FFF);
            need_flag = 1'b1;
          end
          c8i_pkg::FN_FONT: begin
            // glyph address: base plus five times the digit (4v + v)
            idx_en = 1'b1;
            idx_x  = {4'd0, c8i_pkg::FONT_BASE + {6'd0, va_r[3:0], 2'b00}
                            + {8'd0, va_r[3:0]}};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // status to the sequencer
  logic [5:0] row_sum;
  assign row_sum = {1'b0, vy_r[4:0]} + {1'b0, cnt_r[4:0]};

  always_comb begin
    sts.in_is_exec  = (in_tuser == c8i_pkg::OP_EXEC);
    sts.in_is_write = (in_tuser == c8i_pkg::OP_WRITE);
    sts.clr_last    = (cnt_r == c8i_pkg::ADDR_LAST);
    sts.need_flag   = need_flag;
    sts.is_bcd      = (opc == c8i_pkg::OPC_MISC) && (nn == c8i_pkg::FN_BCD);
    sts.is_store    = (opc == c8i_pkg::OPC_MISC) && (nn == c8i_pkg::FN_STORE);
    sts.is_load     = (opc == c8i_pkg::OPC_MISC) && (nn == c8i_pkg::FN_LOAD);
    sts.is_draw     = (opc == c8i_pkg::OPC_DRW);
    sts.cnt_at_x    = (cnt_r[4:0] == {1'b0, fx});
    sts.cnt_two     = (cnt_r[1:0] == 2'd2);
    sts.draw_end    = (cnt_r[4:0] == {1'b0, fn}) || row_sum[5];
  end

  // main memory ports
  always_comb begin
    case (cmd.mem_rsel)
      c8i_pkg::MR_PC:  mem_raddr = pc_r;
      c8i_pkg::MR_PC1: mem_raddr = pc_r + AW'(1);
      default:         mem_raddr = idx_addr;
    endcase
    case (cmd.mem_wsel)
      c8i_pkg::MW_IN: begin
        mem_waddr = in_addr;
        mem_wdata = in_wdata;
      end
      c8i_pkg::MW_CLR: begin
        mem_waddr = cnt_r;
        mem_wdata = c8i_pkg::boot_byte(cnt_r);
      end
      c8i_pkg::MW_BCD: begin
        mem_waddr = idx_addr;
        mem_wdata = c8i_pkg::bcd_digit(va_r, cnt_r[1:0]);
      end
      default: begin
        mem_waddr = idx_addr;
        mem_wdata = v_rdata;
      end
    endcase
  end

  c8i_ram #(
    .WIDTH(8),
    .DEPTH(c8i_pkg::MEM_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (cmd.mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // data register file ports
  always_comb begin
    case (cmd.v_rsel)
      c8i_pkg::VR_A:  v_raddr = (opc == c8i_pkg::OPC_JOFS && !jump_x_r) ? 4'd0 : fx;
      c8i_pkg::VR_Y:  v_raddr = fy;
      default:        v_raddr = cnt_r[3:0];
    endcase
    case (cmd.v_wsel)
      c8i_pkg::VW_EXEC: begin
        v_waddr = fx;
        v_wdata = wx_data;
      end
      c8i_pkg::VW_FLAG: begin
        v_waddr = c8i_pkg::FLAG_REG;
        v_wdata = {7'd0, flag_r};
      end
      c8i_pkg::VW_LOAD: begin
        v_waddr = cnt_r[3:0];
        v_wdata = mem_rdata;
      end
      default: begin
        v_waddr = cnt_r[3:0];
        v_wdata = 8'd0;
      end
    endcase
    v_we = cmd.v_we && (cmd.v_wsel != c8i_pkg::VW_EXEC || wx_en);
  end

  c8i_ram #(
    .WIDTH(8),
    .DEPTH(c8i_pkg::REG_COUNT)
  ) u_vregs (
    .clk  (clk),
    .we   (v_we),
    .waddr(v_waddr),
    .wdata(v_wdata),
    .raddr(v_raddr),
    .rdata(v_rdata)
  );

  // sprite row for the current draw step
  logic [c8i_pkg::SCREEN_W-1:0] spr;
  logic [c8i_pkg::ROW_W-1:0]    draw_row;
  assign spr      = {mem_rdata, 56'd0} >> va_r[5:0];
  assign draw_row = row_sum[c8i_pkg::ROW_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_y_r <= 1'b0;
      jump_x_r  <= 1'b0;
      pc_r      <= c8i_pkg::START_PC;
      idx_r     <= '0;
      lvl_r     <= '0;
      delay_r   <= '0;
      sound_r   <= '0;
      cnt_r     <= '0;
      for (int r = 0; r < c8i_pkg::SCREEN_H; r++) frame_r[r] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          c8i_pkg::CFG_SHIFT_Y: shift_y_r <= cfg_data;
          default:              jump_x_r  <= cfg_data;
        endcase
      end
      if (cmd.cnt_clr)      cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + AW'(1);
      if (cmd.accept && in_tuser == c8i_pkg::OP_TICK) begin
        if (delay_r != '0) delay_r <= delay_r - 8'd1;
        if (sound_r != '0) sound_r <= sound_r - 8'd1;
      end
      if (cmd.exec) begin
        pc_r <= pc_x;
        if (idx_en)  idx_r   <= idx_x;
        if (dly_en)  delay_r <= va_r;
        if (snd_en)  sound_r <= va_r;
        if (push_en) lvl_r   <= lvl_r + LVL_W'(1);
        if (pop_en)  lvl_r   <= lvl_m1;
        if (cls_en) begin
          for (int r = 0; r < c8i_pkg::SCREEN_H; r++) frame_r[r] <= '0;
        end
      end
      if (cmd.draw_ld) frame_r[draw_row] <= frame_r[draw_row] ^ spr;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_tuser;
      addr_r  <= in_addr;
      keys_r  <= in_keys;
      rnd_r   <= in_rnd;
      chg_r   <= 1'b0;
      wait_r  <= 1'b0;
      fault_r <= 1'b0;
    end
    if (cmd.ir_hi_ld) ir_r[15:8] <= mem_rdata;
    if (cmd.ir_lo_ld) ir_r[7:0]  <= mem_rdata;
    if (cmd.va_ld)    va_r       <= v_rdata;
    if (cmd.exec) begin
      vy_r    <= vy;
      flag_r  <= flag_x;
      chg_r   <= chg_x;
      wait_r  <= wait_x;
      fault_r <= fault_x;
      if (push_en) stack_r[lvl_r[SIX_W-1:0]] <= pc2;
    end
    if (cmd.draw_ld && ((frame_r[draw_row] & spr) != '0)) flag_r <= 1'b1;
    if (cmd.out_load) begin
      out_r[63:0]  <= (op_r == c8i_pkg::OP_READ && addr_r < AW'(c8i_pkg::SCREEN_H))
                      ? frame_r[addr_r[c8i_pkg::ROW_W-1:0]] : '0;
      out_r[75:64] <= pc_r;
      out_r[76]    <= (sound_r != '0);
      out_r[77]    <= chg_r;
      out_r[78]    <= wait_r;
      out_r[79]    <= fault_r;
    end
  end

  assign out_tdata = out_r;

endmodule
`default_nettype wire

FILE: rtl/chip8_interpreter_core.sv
// CHIP-8 interpreter core.
// Input channel in_*: one request per item; in_tuser selects execute one
// instruction, write a memory byte, tick both timers, or read a display row.
// Output channel out_*: exactly one result per request, in order, carrying the
// addressed display row, the program counter and the status flags.
// Config channel cfg_*: index 0 shift source quirk, index 1 jump offset quirk;
// always ready. The user must write it only while no request is in flight;
// the core itself has no check that enforces this.
// After reset the core sweeps main memory and the data registers, loading the
// font, before it takes the first request.
// Memory writes, ticks and row reads go straight to the result. Instructions
// pass through fetch, two register file reads and execute; FX33 adds a write
// per BCD digit, FX55/FX65 add a read and a write per register and DXYN adds a
// read and an XOR write per sprite row plus a flag write. The register file
// and main memory each have one write port and one registered read port.
// One request is worked on at a time; a new request is taken while the
// previous result still waits, and the core holds a finished result in its
// output register when the receiver stalls.
`default_nettype none
module chip8_interpreter_core #(
  parameter int STACK_DEPTH = c8i_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // address[11:0], write_data[19:12], keys[35:20], random_byte[43:36], zero pad
  input  wire logic [c8i_pkg::IN_W-1:0]  in_tdata,
  // operation[1:0]
  input  wire logic [1:0]                in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // row_pixels[63:0], program_counter[75:64], sound_on[76], display_changed[77],
  // waiting_for_key[78], stack_fault[79]
  output logic      [c8i_pkg::OUT_W-1:0] out_tdata,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic                      cfg_data
);

  c8i_pkg::cmd_t cmd;
  c8i_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  c8i_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  c8i_datapath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_tdata(out_tdata)
  );

endmodule
`default_nettype wire

FILE: sim/tb_chip8_interpreter_core.sv
`default_nettype none
module tb_chip8_interpreter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STK       = c8i_pkg::STACK_DEPTH_DEF;
  localparam int MAX_CYC   = 3_000_000;
  localparam int DRAIN_CYC = 80;

  // one request as offered on the input channel
  typedef struct {
    c8i_pkg::item_op_t kind;
    logic [47:0]       payload;
  } core_req_t;

  // one result as it should appear on the output channel
  typedef struct {
    logic [63:0] row;
    logic [11:0] pc;
    logic        snd_on;
    logic        chg;
    logic        wait_key;
    logic        fault;
  } core_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [c8i_pkg::IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = c8i_pkg::OP_EXEC;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [c8i_pkg::OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic cfg_data = 1'b0;

  chip8_interpreter_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  core_req_t pending_reqs[$];
  core_res_t awaited_res[$];
  int fails = 0;
  int req_count = 0;
  int cycles = 0;

  // shadow of the core state
  logic [7:0]  sh_mem [0:c8i_pkg::MEM_DEPTH-1];
  logic [7:0]  sh_v [0:c8i_pkg::REG_COUNT-1];
  logic [15:0] sh_idx;
  logic [11:0] sh_pc;
  logic [11:0] sh_stk [0:STK-1];
  int          sh_lvl;
  logic [7:0]  sh_delay;
  logic [7:0]  sh_sound;
  logic [63:0] sh_frame [0:c8i_pkg::SCREEN_H-1];
  logic        sh_shift_y = 1'b0;
  logic        sh_jump_x = 1'b0;

  // one instruction at the shadow pc
  task automatic exec_ins(input logic [15:0] keys, input logic [7:0] rnd,
                          inout core_res_t r);
    logic [15:0] opw;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy, src;
    logic [11:0] nnn, npc;
    logic [8:0]  s9;
    logic [16:0] s17;
    logic [5:0]  xs;
    logic [4:0]  ys;
    logic [63:0] spr;
    logic        hit, down, f;
    int          row, k;
    opw = {sh_mem[sh_pc], sh_mem[12'(sh_pc + 12'd1)]};
    x = opw[11:8]; y = opw[7:4]; n = opw[3:0]; nn = opw[7:0]; nnn = opw[11:0];
    npc = sh_pc + 12'd2;
    case (opw[15:12])
      c8i_pkg::OPC_SYS: begin
        if (opw == c8i_pkg::INS_CLS) begin
          for (k = 0; k < c8i_pkg::SCREEN_H; k++) sh_frame[k] = '0;
          r.chg = 1'b1;
        end else if (opw == c8i_pkg::INS_RET) begin
          if (sh_lvl == 0) r.fault = 1'b1;
          else begin
            sh_lvl--;
            npc = sh_stk[sh_lvl];
          end
        end
      end
      c8i_pkg::OPC_JMP: npc = nnn;
      c8i_pkg::OPC_CALL: begin
        if (sh_lvl >= STK) r.fault = 1'b1;
        else begin
          sh_stk[sh_lvl] = npc;
          sh_lvl++;
          npc = nnn;
        end
      end
      c8i_pkg::OPC_SEQI: if (sh_v[x] == nn) npc = npc + 12'd2;
      c8i_pkg::OPC_SNEI: if (sh_v[x] != nn) npc = npc + 12'd2;
      c8i_pkg::OPC_SEQR: if (sh_v[x] == sh_v[y]) npc = npc + 12'd2;
      c8i_pkg::OPC_LDI:  sh_v[x] = nn;
      c8i_pkg::OPC_ADDI: sh_v[x] = sh_v[x] + nn;
      c8i_pkg::OPC_ALU: begin
        vx = sh_v[x]; vy = sh_v[y];
        src = sh_shift_y ? vy : vx;
        case (n)
          c8i_pkg::ALU_MOV: sh_v[x] = vy;
          c8i_pkg::ALU_OR:  sh_v[x] = vx | vy;
          c8i_pkg::ALU_AND: sh_v[x] = vx & vy;
          c8i_pkg::ALU_XOR: sh_v[x] = vx ^ vy;
          c8i_pkg::ALU_ADD: begin
            s9 = {1'b0, vx} + {1'b0, vy};
            sh_v[x] = s9[7:0]; sh_v[c8i_pkg::FLAG_REG] = {7'd0, s9[8]};
          end
          c8i_pkg::ALU_SUB: begin
            f = vx >= vy; sh_v[x] = vx - vy; sh_v[c8i_pkg::FLAG_REG] = {7'd0, f};
          end
          c8i_pkg::ALU_SUBN: begin
            f = vy >= vx; sh_v[x] = vy - vx; sh_v[c8i_pkg::FLAG_REG] = {7'd0, f};
          end
          c8i_pkg::ALU_SHR: begin
            sh_v[x] = src >> 1; sh_v[c8i_pkg::FLAG_REG] = {7'd0, src[0]};
          end
          c8i_pkg::ALU_SHL: begin
            sh_v[x] = src << 1; sh_v[c8i_pkg::FLAG_REG] = {7'd0, src[7]};
          end
          default: ;
        endcase
      end
      c8i_pkg::OPC_SNER: if (sh_v[x] != sh_v[y]) npc = npc + 12'd2;
      c8i_pkg::OPC_LDX:  sh_idx = {4'd0, nnn};
      c8i_pkg::OPC_JOFS: npc = nnn + {4'd0, (sh_jump_x ? sh_v[x] : sh_v[0])};
      c8i_pkg::OPC_RND:  sh_v[x] = rnd & nn;
      c8i_pkg::OPC_DRW: begin
        xs = sh_v[x][5:0]; ys = sh_v[y][4:0]; hit = 1'b0;
        for (k = 0; k < n; k++) begin
          row = ys + k;
          if (row < c8i_pkg::SCREEN_H) begin
            spr = {sh_mem[12'(sh_idx + 16'(k))], 56'd0} >> xs;
            if ((sh_frame[row] & spr) != 0) hit = 1'b1;
            sh_frame[row] = sh_frame[row] ^ spr;
          end
        end
        sh_v[c8i_pkg::FLAG_REG] = {7'd0, hit};
        r.chg = 1'b1;
      end
      c8i_pkg::OPC_KEY: begin
        down = (sh_v[x] < 8'd16) && keys[sh_v[x][3:0]];
        if ((nn == c8i_pkg::KEY_DOWN && down) || (nn == c8i_pkg::KEY_UP && !down))
          npc = npc + 12'd2;
      end
      default: begin
        case (nn)
          c8i_pkg::FN_DELAY_RD: sh_v[x] = sh_delay;
          c8i_pkg::FN_KEY_WAIT: begin
            if (keys == 16'd0) begin
              npc = sh_pc;
              r.wait_key = 1'b1;
            end else begin
              for (k = 15; k >= 0; k--) if (keys[k]) sh_v[x] = 8'(k);
            end
          end
          c8i_pkg::FN_DELAY_WR: sh_delay = sh_v[x];
          c8i_pkg::FN_SOUND_WR: sh_sound = sh_v[x];
          c8i_pkg::FN_IDX_ADD: begin
            s17 = {1'b0, sh_idx} + {9'd0, sh_v[x]};
            sh_idx = s17[15:0];
            sh_v[c8i_pkg::FLAG_REG] = {7'd0, (s17 > 17'h0FFF)};
          end
          c8i_pkg::FN_FONT:
            sh_idx = {4'd0, c8i_pkg::FONT_BASE} + 16'(5 * sh_v[x][3:0]);
          c8i_pkg::FN_BCD: begin
            vx = sh_v[x];
            sh_mem[12'(sh_idx)]         = vx / 100;
            sh_mem[12'(sh_idx + 16'd1)] = (vx / 10) % 10;
            sh_mem[12'(sh_idx + 16'd2)] = vx % 10;
          end
          c8i_pkg::FN_STORE:
            for (k = 0; k <= x; k++) sh_mem[12'(sh_idx + 16'(k))] = sh_v[k];
          c8i_pkg::FN_LOAD:
            for (k = 0; k <= x; k++) sh_v[k] = sh_mem[12'(sh_idx + 16'(k))];
          default: ;
        endcase
      end
    endcase
    sh_pc = npc;
  endtask

  // queue one request together with the result it should produce
  task automatic send_req(input c8i_pkg::item_op_t kind, input logic [11:0] addr,
                          input logic [7:0] wd, input logic [15:0] keys,
                          input logic [7:0] rnd);
    core_req_t q;
    core_res_t r;
    r = '{row: '0, pc: '0, snd_on: 1'b0, chg: 1'b0, wait_key: 1'b0, fault: 1'b0};
    case (kind)
      c8i_pkg::OP_EXEC:  exec_ins(keys, rnd, r);
      c8i_pkg::OP_WRITE: sh_mem[addr] = wd;
      c8i_pkg::OP_TICK: begin
        if (sh_delay != 0) sh_delay--;
        if (sh_sound != 0) sh_sound--;
      end
      default: if (addr < c8i_pkg::SCREEN_H) r.row = sh_frame[addr];
    endcase
    r.pc = sh_pc;
    r.snd_on = sh_sound != 0;
    q.kind = kind;
    q.payload = {4'd0, rnd, keys, wd, addr};
    pending_reqs.push_back(q);
    awaited_res.push_back(r);
    req_count++;
  endtask

  // place an instruction at the shadow pc and run it
  task automatic run_ins(input logic [15:0] ins, input logic [15:0] keys, input logic [7:0] rnd);
    send_req(c8i_pkg::OP_WRITE, sh_pc, ins[15:8], 16'($urandom), 8'($urandom));
    send_req(c8i_pkg::OP_WRITE, sh_pc + 12'd1, ins[7:0], 16'($urandom), 8'($urandom));
    send_req(c8i_pkg::OP_EXEC, 12'($urandom), 8'($urandom), keys, rnd);
  endtask

  function automatic logic [15:0] pick_ins();
    logic [15:0] w;
    logic [3:0]  alu_ops [10];
    logic [7:0]  misc_fn [10];
    alu_ops = '{c8i_pkg::ALU_MOV, c8i_pkg::ALU_OR, c8i_pkg::ALU_AND, c8i_pkg::ALU_XOR,
                c8i_pkg::ALU_ADD, c8i_pkg::ALU_SUB, c8i_pkg::ALU_SHR, c8i_pkg::ALU_SUBN,
                c8i_pkg::ALU_SHL, 4'h9};
    misc_fn = '{c8i_pkg::FN_DELAY_RD, c8i_pkg::FN_KEY_WAIT, c8i_pkg::FN_DELAY_WR,
                c8i_pkg::FN_SOUND_WR, c8i_pkg::FN_IDX_ADD, c8i_pkg::FN_FONT,
                c8i_pkg::FN_BCD, c8i_pkg::FN_STORE, c8i_pkg::FN_LOAD, 8'h00};
    w = 16'($urandom);
    case (w[15:12])
      c8i_pkg::OPC_SYS: begin
        case ($urandom_range(0, 2))
          0: w = c8i_pkg::INS_CLS;
          1: w = c8i_pkg::INS_RET;
          default: ;
        endcase
      end
      c8i_pkg::OPC_ALU:
        if ($urandom_range(0, 7) != 0) w[3:0] = alu_ops[$urandom_range(0, 8)];
      c8i_pkg::OPC_KEY: begin
        case ($urandom_range(0, 4))
          0, 1: w[7:0] = c8i_pkg::KEY_DOWN;
          2, 3: w[7:0] = c8i_pkg::KEY_UP;
          default: ;
        endcase
      end
      c8i_pkg::OPC_MISC: begin
        misc_fn[9] = 8'($urandom);
        w[7:0] = misc_fn[$urandom_range(0, 9)];
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] pick_keys();
    logic [15:0] k;
    k = 16'($urandom);
    case ($urandom_range(0, 5))
      0: k = 16'd0;
      1: k = 16'd1 << $urandom_range(0, 15);
      default: ;
    endcase
    return k;
  endfunction

  // wait until every result is back, then let the core settle
  task automatic drain();
    while (pending_reqs.size() != 0 || awaited_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == c8i_pkg::CFG_SHIFT_Y) sh_shift_y = val;
    else sh_jump_x = val;
  endtask

  // request driver
  int  in_gap = 0;
  int  in_done = 0;
  logic in_next;
  core_req_t in_cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      in_next = in_tvalid;
      if (in_tvalid && in_tready) begin
        in_next = 1'b0;
        in_done++;
        in_gap = ((in_done / 100) % 3 == 1) ? 0 : $urandom_range(0, 12);
      end
      if (!in_next) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() != 0) begin
          in_cur = pending_reqs.pop_front();
          in_tdata <= in_cur.payload;
          in_tuser <= in_cur.kind;
          in_next = 1'b1;
        end
      end
      in_tvalid <= in_next;
    end
  end

  // result monitor and checker
  int out_wait = 0;
  int out_hold = 0;
  int out_done = 0;
  logic out_next;
  core_res_t got, want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.row = out_tdata[63:0];
        got.pc = out_tdata[75:64];
        got.snd_on = out_tdata[76];
        got.chg = out_tdata[77];
        got.wait_key = out_tdata[78];
        got.fault = out_tdata[79];
        if (awaited_res.size() == 0) begin
          if (fails < 10) $display("unexpected result %h", out_tdata);
          fails++;
        end else begin
          want = awaited_res.pop_front();
          if (got.row !== want.row || got.pc !== want.pc || got.snd_on !== want.snd_on ||
              got.chg !== want.chg || got.wait_key !== want.wait_key ||
              got.fault !== want.fault) begin
            if (fails < 10)
              $display({"result %0d: exp row=%h pc=%h snd=%b chg=%b wait=%b flt=%b,",
                        " got row=%h pc=%h snd=%b chg=%b wait=%b flt=%b"},
                       out_done, want.row, want.pc, want.snd_on, want.chg, want.wait_key,
                       want.fault, got.row, got.pc, got.snd_on, got.chg, got.wait_key,
                       got.fault);
            fails++;
          end
        end
        out_done++;
        out_wait = ((out_done / 80) % 3 == 2) ? 0 : $urandom_range(0, 12);
        // one long back-pressure stretch so the core fills and stalls its input
        if (out_done == 150) out_hold = 400;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_next = 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_next = 1'b0;
      end else begin
        out_next = 1'b1;
      end
      out_tready <= out_next;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  logic [1:0] cfg_set [4];
  int ph, k, goal;
  initial begin
    cfg_set = '{2'b00, 2'b11, 2'b01, 2'b10};
    for (k = 0; k < c8i_pkg::MEM_DEPTH; k++) sh_mem[k] = 8'h00;
    for (k = 0; k < c8i_pkg::FONT_BYTES; k++)
      sh_mem[c8i_pkg::FONT_BASE + k] = c8i_pkg::FONT_ROM[k];
    for (k = 0; k < c8i_pkg::REG_COUNT; k++) sh_v[k] = 8'h00;
    for (k = 0; k < STK; k++) sh_stk[k] = '0;
    for (k = 0; k < c8i_pkg::SCREEN_H; k++) sh_frame[k] = '0;
    sh_idx = '0; sh_pc = c8i_pkg::START_PC; sh_lvl = 0; sh_delay = '0; sh_sound = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < 4; ph++) begin
      drain();
      write_cfg(c8i_pkg::CFG_SHIFT_Y, cfg_set[ph][0]);
      write_cfg(c8i_pkg::CFG_JUMP_X, cfg_set[ph][1]);
      if (ph == 0) begin
        // return on an empty stack
        run_ins(c8i_pkg::INS_RET, 16'hFFFF, 8'hFF);
        // sprite at the bottom right corner with wrapping index and clipping
        run_ins(16'h6E3D, 16'h0000, 8'h00);
        run_ins(16'hAFFE, 16'h8000, 8'hA5);
        send_req(c8i_pkg::OP_WRITE, 12'h000, 8'hFF, 16'h0000, 8'h00);
        run_ins(16'hDEE5, 16'h0001, 8'h00);
        // key wait with nothing pressed
        run_ins(16'hF00A, 16'h0000, 8'h00);
        // subtraction with the flag register as destination
        run_ins(16'h8FE7, 16'hFFFF, 8'hFF);
        send_req(c8i_pkg::OP_READ, 12'd31, 8'h00, 16'h0000, 8'h00);
        send_req(c8i_pkg::OP_READ, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_req(c8i_pkg::OP_TICK, 12'h000, 8'h00, 16'h0000, 8'h00);
      end
      goal = req_count + 125;
      while (req_count < goal) begin
        case ($urandom_range(0, 19))
          0: send_req(c8i_pkg::OP_TICK, 12'($urandom), 8'($urandom), 16'($urandom),
                      8'($urandom));
          1: send_req(c8i_pkg::OP_READ, ($urandom_range(0, 7) == 0) ? 12'($urandom) :
                      12'($urandom_range(0, c8i_pkg::SCREEN_H - 1)), 8'($urandom),
                      16'($urandom), 8'($urandom));
          2: send_req(c8i_pkg::OP_WRITE, 12'($urandom), 8'($urandom), 16'($urandom),
                      8'($urandom));
          3: send_req(c8i_pkg::item_op_t'($urandom_range(0, 3)), 12'($urandom),
                      8'($urandom), 16'($urandom), 8'($urandom));
          4: begin
            // deep call chain to reach the stack limit
            if ($urandom_range(0, 9) == 0)
              for (k = 0; k < STK + 2; k++)
                run_ins({c8i_pkg::OPC_CALL, 12'($urandom)}, 16'h0, 8'h0);
            else
              run_ins(pick_ins(), pick_keys(), 8'($urandom));
          end
          default: run_ins(pick_ins(), pick_keys(), 8'($urandom));
        endcase
      end
    end

    drain();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: chip8_interpreter_core.f
rtl/c8i_pkg.sv
rtl/c8i_ram.sv
rtl/c8i_ctrl.sv
rtl/c8i_datapath.sv
rtl/chip8_interpreter_core.sv
sim/tb_chip8_interpreter_core.sv
